[rtl/pngcsp_pkg.sv]
`default_nettype none

package pngcsp_pkg;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_SIG     = 3'd1;
  localparam logic [2:0] ST_NOT_IHDR    = 3'd2;
  localparam logic [2:0] ST_ZERO_SIZE   = 3'd3;
  localparam logic [2:0] ST_BAD_COMPR   = 3'd4;
  localparam logic [2:0] ST_BAD_FILTER  = 3'd5;

  // chunk kind codes
  localparam logic [2:0] K_IHDR  = 3'd0;
  localparam logic [2:0] K_PLTE  = 3'd1;
  localparam logic [2:0] K_SRGB  = 3'd2;
  localparam logic [2:0] K_IDAT  = 3'd3;
  localparam logic [2:0] K_GAMA  = 3'd4;
  localparam logic [2:0] K_PHYS  = 3'd5;
  localparam logic [2:0] K_IEND  = 3'd6;
  localparam logic [2:0] K_OTHER = 3'd7;

  // chunk type codes, big-endian ascii
  localparam logic [31:0] T_PLTE = 32'h504C5445;
  localparam logic [31:0] T_SRGB = 32'h73524742;
  localparam logic [31:0] T_IDAT = 32'h49444154;
  localparam logic [31:0] T_GAMA = 32'h67414D41;
  localparam logic [31:0] T_PHYS = 32'h70485973;
  localparam logic [31:0] T_IEND = 32'h49454E44;

  // file signature and the required first chunk type
  localparam logic [7:0] SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};
  localparam logic [7:0] IHDR_BYTES [4] = '{8'd73, 8'd72, 8'd68, 8'd82};

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  chunk_kind;
    logic [31:0] chunk_length;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  color_type;
    logic [7:0]  interlace_method;
    logic        end_of_image;
  } res_t;

  // chunk type to kind code
  function automatic logic [2:0] kind_of(input logic [31:0] t);
    case (t)
      T_PLTE:  return K_PLTE;
      T_SRGB:  return K_SRGB;
      T_IDAT:  return K_IDAT;
      T_GAMA:  return K_GAMA;
      T_PHYS:  return K_PHYS;
      T_IEND:  return K_IEND;
      default: return K_OTHER;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/pngcsp_in_reg.sv]
`default_nettype none

module pngcsp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pngcsp_pkg::item_t in_item,
  output logic                   held_valid,
  output pngcsp_pkg::item_t      held_item,
  input  wire logic              take
);
  import pngcsp_pkg::*;

  // room when empty or when the held item moves on this cycle
  assign in_ready = !held_valid || take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/pngcsp_core.sv]
`default_nettype none

module pngcsp_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              held_valid,
  input  wire pngcsp_pkg::item_t held_item,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pngcsp_pkg::res_t       out_res
);
  import pngcsp_pkg::*;

  typedef enum logic [3:0] {
    PH_SIG, PH_IHDR_LEN, PH_IHDR_TYPE, PH_IHDR_DATA, PH_IHDR_CRC,
    PH_LEN, PH_TYPE, PH_SKIP, PH_DONE
  } phase_t;

  phase_t      phase, phase_e, phase_next;
  logic [32:0] pos, pos_e, pos_next, pos_inc, skip_end;
  logic [31:0] cur_len, len_e, len_next;
  logic [31:0] cur_type, typ_e, typ_next;
  logic [31:0] width_store, w_e, w_next;
  logic [31:0] height_store, h_e, h_next;
  logic [23:0] header_bytes, hdr_e, hdr_next;
  logic        error_halt, halt_e, halt_next;
  logic        res_valid;
  res_t        res;
  logic [7:0]  b;
  logic [2:0]  kind;

  // the held item moves when the result register has room
  assign take = held_valid && (!out_valid || out_ready);

  assign b        = held_item.data_byte;
  assign pos_inc  = pos_e + 33'd1;
  assign skip_end = {1'b0, len_e} + 33'd4;
  assign kind     = kind_of(typ_e);

  // parse step for one byte
  always_comb begin
    // a new file restarts from the reset state
    if (held_item.file_start) begin
      phase_e = PH_SIG;
      pos_e   = '0;
      len_e   = '0;
      typ_e   = '0;
      w_e     = '0;
      h_e     = '0;
      hdr_e   = '0;
      halt_e  = 1'b0;
    end else begin
      phase_e = phase;
      pos_e   = pos;
      len_e   = cur_len;
      typ_e   = cur_type;
      w_e     = width_store;
      h_e     = height_store;
      hdr_e   = header_bytes;
      halt_e  = error_halt;
    end

    phase_next = phase_e;
    pos_next   = pos_e;
    len_next   = len_e;
    typ_next   = typ_e;
    w_next     = w_e;
    h_next     = h_e;
    hdr_next   = hdr_e;
    halt_next  = halt_e;
    res_valid  = 1'b0;
    res.status       = ST_OK;
    res.chunk_kind   = K_IHDR;
    res.chunk_length = '0;
    res.end_of_image = 1'b0;

    if (!halt_e) begin
      case (phase_e)
        PH_SIG: begin
          if (b != SIG_BYTES[pos_e[2:0]]) begin
            halt_next  = 1'b1;
            res_valid  = 1'b1;
            res.status = ST_BAD_SIG;
          end else if (pos_e[2:0] == 3'd7) begin
            phase_next = PH_IHDR_LEN;
            pos_next   = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_IHDR_LEN, PH_LEN: begin
          len_next = {len_e[23:0], b};
          if (pos_e[1:0] == 2'd3) begin
            phase_next = (phase_e == PH_LEN) ? PH_TYPE : PH_IHDR_TYPE;
            pos_next   = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_IHDR_TYPE: begin
          if (b != IHDR_BYTES[pos_e[1:0]]) begin
            halt_next  = 1'b1;
            res_valid  = 1'b1;
            res.status = ST_NOT_IHDR;
          end else begin
            typ_next = {typ_e[23:0], b};
            if (pos_e[1:0] == 2'd3) begin
              phase_next = PH_IHDR_DATA;
              pos_next   = '0;
            end else begin
              pos_next = pos_inc;
            end
          end
        end
        PH_IHDR_DATA: begin
          // header fields by position
          case (pos_e[3:0])
            4'd0, 4'd1, 4'd2, 4'd3: w_next = {w_e[23:0], b};
            4'd4, 4'd5, 4'd6:       h_next = {h_e[23:0], b};
            4'd7: begin
              h_next = {h_e[23:0], b};
              if (w_e == '0 || {h_e[23:0], b} == '0) begin
                halt_next  = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_ZERO_SIZE;
              end
            end
            4'd8: hdr_next[23:16] = b;
            4'd9: hdr_next[15:8]  = b;
            4'd10: begin
              if (b != 8'd0) begin
                halt_next  = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_BAD_COMPR;
              end
            end
            4'd11: begin
              if (b != 8'd0) begin
                halt_next  = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_BAD_FILTER;
              end
            end
            default: hdr_next[7:0] = b;
          endcase
          if (pos_e[3:0] == 4'd12) begin
            phase_next = PH_IHDR_CRC;
            pos_next   = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_IHDR_CRC: begin
          if (pos_e[1:0] == 2'd3) begin
            phase_next       = PH_LEN;
            pos_next         = '0;
            res_valid        = 1'b1;
            res.chunk_length = len_e;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_TYPE: begin
          typ_next = {typ_e[23:0], b};
          if (pos_e[1:0] == 2'd3) begin
            phase_next = PH_SKIP;
            pos_next   = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_SKIP: begin
          // data bytes and crc skipped
          if (pos_inc == skip_end) begin
            phase_next       = (kind == K_IEND) ? PH_DONE : PH_LEN;
            pos_next         = '0;
            len_next         = '0;
            typ_next         = '0;
            res_valid        = 1'b1;
            res.chunk_kind   = kind;
            res.chunk_length = len_e;
            res.end_of_image = (kind == K_IEND);
          end else begin
            pos_next = pos_inc;
          end
        end
        default: begin
          phase_next = phase_e;
        end
      endcase
    end

    res.image_width      = w_next;
    res.image_height     = h_next;
    res.bit_depth        = hdr_next[23:16];
    res.color_type       = hdr_next[15:8];
    res.interlace_method = hdr_next[7:0];
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      pos          <= '0;
      cur_len      <= '0;
      cur_type     <= '0;
      width_store  <= '0;
      height_store <= '0;
      header_bytes <= '0;
      error_halt   <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      pos          <= pos_next;
      cur_len      <= len_next;
      cur_type     <= typ_next;
      width_store  <= w_next;
      height_store <= h_next;
      header_bytes <= hdr_next;
      error_halt   <= halt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res <= res;
    end
  end

  // an error result halts the parse
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.status != ST_OK |=> error_halt)
    else $error("error result did not set halt");

  // halted without restart stays silent
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    take && error_halt && !held_item.file_start |-> !res_valid)
    else $error("result while halted");

  // nothing after the last chunk until restart
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DONE && !held_item.file_start |-> !res_valid)
    else $error("result after end of image");

  // the last chunk closes the file
  a_eoi_done: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.end_of_image |=> phase == PH_DONE)
    else $error("end of image without done phase");

endmodule

`default_nettype wire

[rtl/png_chunk_stream_parser.sv]
// PNG chunk stream parser
// Input channel: one file byte per item (data_byte) with file_start marking
// the first byte of a new file, handshaked by in_valid / in_ready.
// Output channel: one item per finished chunk or per detected error,
// handshaked by out_valid / out_ready. An error item carries a nonzero
// status and silences the block until the next file_start; after IEND the
// block stays silent the same way.
// Path: an accepted byte waits in the input register, is parsed when it
// moves on, and any result it causes is held in the result register.
// Throughput: one byte per cycle unless a result waits untaken; each byte
// is one pass of the parse step between the input and result registers.
// Reset: rst clears both registers and puts the parser in the signature
// phase with all captured header fields at zero.
// Stall: while a result waits in the output register, the input register
// still takes one more byte if empty; input stalls until the result is taken.
`default_nettype none

module png_chunk_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        file_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [2:0]       chunk_kind,
  output logic [31:0]      chunk_length,
  output logic [31:0]      image_width,
  output logic [31:0]      image_height,
  output logic [7:0]       bit_depth,
  output logic [7:0]       color_type,
  output logic [7:0]       interlace_method,
  output logic             end_of_image
);
  import pngcsp_pkg::*;

  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  take;
  res_t  out_res;

  assign in_item.data_byte  = data_byte;
  assign in_item.file_start = file_start;

  // input register
  pngcsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  // parse step and result register
  pngcsp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign status           = out_res.status;
  assign chunk_kind       = out_res.chunk_kind;
  assign chunk_length     = out_res.chunk_length;
  assign image_width      = out_res.image_width;
  assign image_height     = out_res.image_height;
  assign bit_depth        = out_res.bit_depth;
  assign color_type       = out_res.color_type;
  assign interlace_method = out_res.interlace_method;
  assign end_of_image     = out_res.end_of_image;

endmodule

`default_nettype wire
